// ===== rtl/pmc_pkg.sv =====
// pmc_pkg: shared types and constants for the pixel mask collision block.
// Item structs, the front-to-back queue entry and register indexes.
// No dependencies.
package pmc_pkg;

    localparam int MAX_SPRITE_W_DEF = 64;
    localparam int MAX_SPRITE_H_DEF = 64;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int SIZE_W     = 7;
    localparam int POS_W      = 10;
    localparam int COLOR_W    = 24;
    localparam int PIX_W      = 6;
    localparam int Q_DEPTH    = 4;

    localparam logic [COLOR_W-1:0] KEY_COLOR_RST = 24'hff00ff;
    localparam logic [SIZE_W-1:0]  SIZE_RST      = 7'd35;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_WIDTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_A_HEIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B_HEIGHT  = 3'd4;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef struct packed {
        logic               func;
        logic               sprite_sel;
        logic [PIX_W-1:0]   pix_col;
        logic [PIX_W-1:0]   pix_row;
        logic [COLOR_W-1:0] pix_color;
        logic [POS_W-1:0]   a_pos_x;
        logic [POS_W-1:0]   a_pos_y;
        logic [POS_W-1:0]   b_pos_x;
        logic [POS_W-1:0]   b_pos_y;
    } in_item_t;

    typedef struct packed {
        logic hit;
        logic boxes_overlap;
    } out_item_t;

    // One classified item: a mask write or a prepared query.
    typedef struct packed {
        logic              is_query;
        // load
        logic              sel;
        logic              wr_ok;
        logic              opaque;
        logic [PIX_W-1:0]  row;
        logic [PIX_W-1:0]  col;
        // query
        logic              overlap;
        logic [PIX_W-1:0]  sa;
        logic [PIX_W-1:0]  sb;
        logic [SIZE_W-1:0] ra;
        logic [SIZE_W-1:0] rb;
        logic [SIZE_W-1:0] cw;
        logic [SIZE_W-1:0] ch;
    } q_entry_t;

endpackage

// ===== rtl/pmc_fifo.sv =====
// pmc_fifo: short queue of classified items between front and back.
// Depends on pmc_pkg.
module pmc_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pmc_pkg::q_entry_t push_entry,
    output logic              not_full,
    input  logic              pop,
    output logic              head_valid,
    output pmc_pkg::q_entry_t head
);
    localparam int PW = $clog2(pmc_pkg::Q_DEPTH);
    localparam int CW = $clog2(pmc_pkg::Q_DEPTH + 1);

    pmc_pkg::q_entry_t q_mem_reg [pmc_pkg::Q_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_full   = (count_reg != CW'(pmc_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = q_mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(pmc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(pmc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/pmc_front.sv =====
// pmc_front: configuration registers and item classification.
// Loads get their opacity decided here, queries their overlap rectangle.
// Depends on pmc_pkg.
module pmc_front #(
    parameter int MAX_SPRITE_W = pmc_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = pmc_pkg::MAX_SPRITE_H_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  pmc_pkg::in_item_t               item,
    output pmc_pkg::q_entry_t               entry
);
    localparam int SW = pmc_pkg::SIZE_W;
    localparam int PW = pmc_pkg::POS_W;

    logic [pmc_pkg::COLOR_W-1:0] key_color_reg;
    logic [SW-1:0] a_width_reg, a_height_reg, b_width_reg, b_height_reg;

    logic [SW-1:0] aw, ah, bw, bh;
    logic [PW:0]   ax_end, ay_end, bx_end, by_end;
    logic [PW:0]   x_end, y_end;
    logic [PW-1:0] cx, cy;
    logic [PW:0]   cw_full, ch_full;
    logic [PW-1:0] sa_full, sb_full, ra_full, rb_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_color_reg <= pmc_pkg::KEY_COLOR_RST;
            a_width_reg   <= pmc_pkg::SIZE_RST;
            a_height_reg  <= pmc_pkg::SIZE_RST;
            b_width_reg   <= pmc_pkg::SIZE_RST;
            b_height_reg  <= pmc_pkg::SIZE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                pmc_pkg::REG_KEY_COLOR: key_color_reg <= cfg_wdata[pmc_pkg::COLOR_W-1:0];
                pmc_pkg::REG_A_WIDTH:   a_width_reg   <= cfg_wdata[SW-1:0];
                pmc_pkg::REG_A_HEIGHT:  a_height_reg  <= cfg_wdata[SW-1:0];
                pmc_pkg::REG_B_WIDTH:   b_width_reg   <= cfg_wdata[SW-1:0];
                pmc_pkg::REG_B_HEIGHT:  b_height_reg  <= cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    // sizes clamped to 1..max
    always_comb begin
        aw = (a_width_reg == '0) ? SW'(1) :
             ((9'(a_width_reg) > 9'(MAX_SPRITE_W)) ? SW'(MAX_SPRITE_W) : a_width_reg);
        bw = (b_width_reg == '0) ? SW'(1) :
             ((9'(b_width_reg) > 9'(MAX_SPRITE_W)) ? SW'(MAX_SPRITE_W) : b_width_reg);
        ah = (a_height_reg == '0) ? SW'(1) :
             ((9'(a_height_reg) > 9'(MAX_SPRITE_H)) ? SW'(MAX_SPRITE_H) : a_height_reg);
        bh = (b_height_reg == '0) ? SW'(1) :
             ((9'(b_height_reg) > 9'(MAX_SPRITE_H)) ? SW'(MAX_SPRITE_H) : b_height_reg);
    end

    always_comb begin
        ax_end = {1'b0, item.a_pos_x} + (PW+1)'(aw);
        ay_end = {1'b0, item.a_pos_y} + (PW+1)'(ah);
        bx_end = {1'b0, item.b_pos_x} + (PW+1)'(bw);
        by_end = {1'b0, item.b_pos_y} + (PW+1)'(bh);

        cx    = (item.a_pos_x > item.b_pos_x) ? item.a_pos_x : item.b_pos_x;
        cy    = (item.a_pos_y > item.b_pos_y) ? item.a_pos_y : item.b_pos_y;
        x_end = (ax_end < bx_end) ? ax_end : bx_end;
        y_end = (ay_end < by_end) ? ay_end : by_end;

        cw_full = x_end - {1'b0, cx};
        ch_full = y_end - {1'b0, cy};
        sa_full = cx - item.a_pos_x;
        sb_full = cx - item.b_pos_x;
        ra_full = cy - item.a_pos_y;
        rb_full = cy - item.b_pos_y;

        entry          = '0;
        entry.is_query = (item.func == pmc_pkg::FUNC_QUERY);
        entry.sel      = item.sprite_sel;
        entry.opaque   = (item.pix_color != key_color_reg);
        // columns past the widest sprite and rows past the mask are never read
        entry.wr_ok    = (7'(item.pix_col) < 7'(MAX_SPRITE_W)) &&
                         (9'(item.pix_row) < 9'(MAX_SPRITE_H));
        entry.row      = item.pix_row;
        entry.col      = item.pix_col;
        entry.overlap  = ({1'b0, item.a_pos_x} < bx_end) && ({1'b0, item.b_pos_x} < ax_end) &&
                         ({1'b0, item.a_pos_y} < by_end) && ({1'b0, item.b_pos_y} < ay_end);
        entry.sa       = sa_full[pmc_pkg::PIX_W-1:0];
        entry.sb       = sb_full[pmc_pkg::PIX_W-1:0];
        entry.ra       = ra_full[SW-1:0];
        entry.rb       = rb_full[SW-1:0];
        entry.cw       = cw_full[SW-1:0];
        entry.ch       = ch_full[SW-1:0];
    end

endmodule

// ===== rtl/pmc_back.sv =====
// pmc_back: mask memories, row walk over the overlap and result register.
// Depends on pmc_pkg.
module pmc_back #(
    parameter int MAX_SPRITE_W = pmc_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = pmc_pkg::MAX_SPRITE_H_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               head_valid,
    input  pmc_pkg::q_entry_t  head,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output pmc_pkg::out_item_t m_item
);
    localparam int AW = $clog2(MAX_SPRITE_H);
    localparam int CW = $clog2(MAX_SPRITE_W);
    localparam int SW = pmc_pkg::SIZE_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [MAX_SPRITE_W-1:0] mask_a_mem [MAX_SPRITE_H];
    logic [MAX_SPRITE_W-1:0] mask_b_mem [MAX_SPRITE_H];
    logic [MAX_SPRITE_W-1:0] rd_a_reg, rd_b_reg;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] row_a_reg, row_a_next, row_b_reg, row_b_next;
    logic [SW-1:0] left_reg, left_next;
    logic [pmc_pkg::PIX_W-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [MAX_SPRITE_W-1:0]   wmask_reg, wmask_next;
    logic          hit_reg, hit_next, ovl_reg, ovl_next;
    logic          m_valid_reg, m_valid_next;
    pmc_pkg::out_item_t m_item_reg, m_item_next;

    logic [AW-1:0] rd_addr_a, rd_addr_b;
    logic          wr_a, wr_b;
    logic [AW-1:0] wr_row;
    logic [CW-1:0] wr_col;
    logic [MAX_SPRITE_W-1:0] pa, pb, new_wmask;
    logic          row_hit;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    assign pop    = (state_reg == ST_IDLE) && head_valid;
    assign wr_row = AW'(head.row);
    assign wr_col = CW'(head.col);
    assign wr_a   = pop && !head.is_query && head.wr_ok && !head.sel;
    assign wr_b   = pop && !head.is_query && head.wr_ok && head.sel;

    assign rd_addr_a = (state_reg == ST_IDLE) ? AW'(head.ra) : row_a_reg;
    assign rd_addr_b = (state_reg == ST_IDLE) ? AW'(head.rb) : row_b_reg;

    always_comb begin
        for (int i = 0; i < MAX_SPRITE_W; i++) begin
            new_wmask[i] = (8'(i) < 8'(head.cw));
        end
    end

    // both rows aligned to the overlap's left edge
    assign pa      = rd_a_reg >> sa_reg;
    assign pb      = rd_b_reg >> sb_reg;
    assign row_hit = |(pa & pb & wmask_reg);

    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mask_a_mem[wr_row][wr_col] <= head.opaque;
        end
        if (wr_b) begin
            mask_b_mem[wr_row][wr_col] <= head.opaque;
        end
        rd_a_reg <= mask_a_mem[rd_addr_a];
        rd_b_reg <= mask_b_mem[rd_addr_b];
    end

    always_comb begin
        state_next   = state_reg;
        row_a_next   = row_a_reg;
        row_b_next   = row_b_reg;
        left_next    = left_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        wmask_next   = wmask_reg;
        hit_next     = hit_reg;
        ovl_next     = ovl_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop && head.is_query) begin
                    hit_next = 1'b0;
                    ovl_next = head.overlap;
                    if (head.overlap) begin
                        // first row read is issued now
                        row_a_next = AW'(head.ra) + AW'(1);
                        row_b_next = AW'(head.rb) + AW'(1);
                        left_next  = head.ch - SW'(1);
                        sa_next    = head.sa;
                        sb_next    = head.sb;
                        wmask_next = new_wmask;
                        state_next = ST_WALK;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_WALK: begin
                if (row_hit) begin
                    hit_next   = 1'b1;
                    state_next = ST_DONE;
                end else if (left_reg == '0) begin
                    state_next = ST_DONE;
                end else begin
                    row_a_next = row_a_reg + AW'(1);
                    row_b_next = row_b_reg + AW'(1);
                    left_next  = left_reg - SW'(1);
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_item_next.hit           = hit_reg;
                    m_item_next.boxes_overlap = ovl_reg;
                    state_next                = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        row_a_reg  <= row_a_next;
        row_b_reg  <= row_b_next;
        left_reg   <= left_next;
        sa_reg     <= sa_next;
        sb_reg     <= sb_next;
        wmask_reg  <= wmask_next;
        hit_reg    <= hit_next;
        ovl_reg    <= ovl_next;
        m_item_reg <= m_item_next;
    end

endmodule

// ===== rtl/pixel_mask_collision.sv =====
// pixel_mask_collision: top level of the sprite pixel collision block.
// Depends on pmc_pkg, pmc_front, pmc_fifo and pmc_back.
//
// Usage:
//   s_ channel (valid/ready) takes items: func=0 loads one pixel of sprite A
//   or B (opaque unless its color equals key_color), func=1 is a query with
//   both sprites' top-left screen positions. Loads give no result; each query
//   gives one item on the m_ channel (hit, boxes_overlap).
//   cfg_we/cfg_index/cfg_wdata write key_color and the four sprite sizes;
//   write them only while no item is in flight.
// Flow:
//   The front classifies an item in its accept cycle and queues it (4 deep).
//   The back pops one item per cycle while idle; a load is written to its mask
//   as it leaves the queue. A query's pop cycle issues the first row reads;
//   the walk then checks one row of each mask per cycle over the overlap rows,
//   stopping at the first row with a hit, and the result then goes into the
//   output register, where it waits while m_ready is low. A query without box
//   overlap skips the walk. The back takes no new item until the result of a
//   query has entered the output register.
// Reset (aresetn, synchronous): queue empty, output empty, registers back to
//   their defaults. Mask memories are not cleared; load pixels before use.
// Stall: a held result keeps the back end waiting; the queue still takes new
//   items until it fills, then s_ready drops.
module pixel_mask_collision #(
    parameter int MAX_SPRITE_W = pmc_pkg::MAX_SPRITE_W_DEF,
    parameter int MAX_SPRITE_H = pmc_pkg::MAX_SPRITE_H_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pmc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  pmc_pkg::in_item_t              s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output pmc_pkg::out_item_t             m_item
);
    pmc_pkg::q_entry_t push_entry;
    pmc_pkg::q_entry_t head;
    logic              q_not_full;
    logic              head_valid;
    logic              pop;
    logic              push;

    assign s_ready = q_not_full;
    assign push    = s_valid && q_not_full;

    // front: config registers and per-item classification
    pmc_front #(
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (s_item),
        .entry     (push_entry)
    );

    // queue keeps loads and queries in order
    pmc_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .not_full   (q_not_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: mask writes, row walk, result register
    pmc_back #(
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item)
    );

endmodule

// ===== rtl/pmc_checker.sv =====
// pmc_checker: port-level assertions for pixel_mask_collision, and its bind.
// Depends on pmc_pkg.
module pmc_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input pmc_pkg::out_item_t m_item
);
    // a hit needs overlapping boxes
    a_hit_needs_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_item.hit || m_item.boxes_overlap))
        else $error("hit reported without box overlap");

    // output comes out of reset empty
    a_empty_after_reset: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_item)))
        else $error("result changed or dropped while stalled");

endmodule

bind pixel_mask_collision pmc_checker u_pmc_checker (.*);

// ===== dv/pixel_mask_collision_tb.sv =====
// pixel_mask_collision_tb: self-checking testbench for the sprite collision block.
// Holds a mask scoreboard class that predicts every query result; depends on pmc_pkg
// and the pixel_mask_collision RTL.
module pixel_mask_collision_tb;

    // Mask scoreboard: own copy of both opacity masks and the register file,
    // predicts the result of every accepted query and checks the block's output.
    class collision_scoreboard;
        bit [63:0]   opaque_a [64];
        bit [63:0]   opaque_b [64];
        logic [23:0] key;
        int          a_w, a_h, b_w, b_h;
        pmc_pkg::out_item_t pending [$];
        int          errors, n_loads, n_queries, n_overlaps, n_hits;

        function new();
            key = pmc_pkg::KEY_COLOR_RST;
            a_w = int'(pmc_pkg::SIZE_RST);
            a_h = int'(pmc_pkg::SIZE_RST);
            b_w = int'(pmc_pkg::SIZE_RST);
            b_h = int'(pmc_pkg::SIZE_RST);
        endfunction

        static function int fit_size(int v, int top);
            return (v < 1) ? 1 : ((v > top) ? top : v);
        endfunction

        function void set_reg(logic [pmc_pkg::CFG_IDX_W-1:0] idx,
                              logic [pmc_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                pmc_pkg::REG_KEY_COLOR: key = data;
                pmc_pkg::REG_A_WIDTH:   a_w = int'(data[pmc_pkg::SIZE_W-1:0]);
                pmc_pkg::REG_A_HEIGHT:  a_h = int'(data[pmc_pkg::SIZE_W-1:0]);
                pmc_pkg::REG_B_WIDTH:   b_w = int'(data[pmc_pkg::SIZE_W-1:0]);
                pmc_pkg::REG_B_HEIGHT:  b_h = int'(data[pmc_pkg::SIZE_W-1:0]);
                default: ;
            endcase
        endfunction

        // Overlap rectangle in each sprite's own coordinates; 0 if the boxes miss.
        function bit overlap_rect(pmc_pkg::in_item_t it, output int a_col0,
                                  output int b_col0, output int a_row0,
                                  output int b_row0, output int cw, output int ch);
            int aw, ah, bw, bh, ax, ay, bx, by, cx, cy;
            aw = fit_size(a_w, pmc_pkg::MAX_SPRITE_W_DEF);
            ah = fit_size(a_h, pmc_pkg::MAX_SPRITE_H_DEF);
            bw = fit_size(b_w, pmc_pkg::MAX_SPRITE_W_DEF);
            bh = fit_size(b_h, pmc_pkg::MAX_SPRITE_H_DEF);
            ax = int'(it.a_pos_x);
            ay = int'(it.a_pos_y);
            bx = int'(it.b_pos_x);
            by = int'(it.b_pos_y);
            a_col0 = 0;
            b_col0 = 0;
            a_row0 = 0;
            b_row0 = 0;
            cw = 0;
            ch = 0;
            if (!(ax < bx + bw && bx < ax + aw && ay < by + bh && by < ay + ah))
                return 1'b0;
            cx = (ax > bx) ? ax : bx;
            cy = (ay > by) ? ay : by;
            // clip to the nearer far edge on both axes
            cw = ((ax + aw < bx + bw) ? ax + aw : bx + bw) - cx;
            ch = ((ay + ah < by + bh) ? ay + ah : by + bh) - cy;
            a_col0 = cx - ax;
            b_col0 = cx - bx;
            a_row0 = cy - ay;
            b_row0 = cy - by;
            return 1'b1;
        endfunction

        function void note_item(pmc_pkg::in_item_t it);
            pmc_pkg::out_item_t want;
            logic [63:0] win, pa, pb;
            int          a_col0, b_col0, a_row0, b_row0, cw, ch;
            if (it.func == pmc_pkg::FUNC_LOAD) begin
                // opacity is fixed here, a later key change leaves it alone
                if (it.sprite_sel) opaque_b[it.pix_row][it.pix_col] = (it.pix_color != key);
                else               opaque_a[it.pix_row][it.pix_col] = (it.pix_color != key);
                n_loads++;
                return;
            end
            want = '0;
            want.boxes_overlap = overlap_rect(it, a_col0, b_col0, a_row0, b_row0, cw, ch);
            if (want.boxes_overlap) begin
                win = (cw >= 64) ? '1 : ((64'd1 << cw) - 64'd1);
                for (int r = 0; r < ch; r++) begin
                    pa = (opaque_a[a_row0 + r] >> a_col0) & win;
                    pb = (opaque_b[b_row0 + r] >> b_col0) & win;
                    if ((pa & pb) != 64'd0) begin
                        want.hit = 1'b1;
                        break;
                    end
                end
                n_overlaps++;
            end
            if (want.hit) n_hits++;
            n_queries++;
            pending.push_back(want);
        endfunction

        function void check_result(pmc_pkg::out_item_t got);
            pmc_pkg::out_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual hit=%b overlap=%b",
                         $time, got.hit, got.boxes_overlap);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit) begin
                $display("%0t: hit mismatch, expected %b actual %b", $time, want.hit, got.hit);
                errors++;
            end
            if (got.boxes_overlap !== want.boxes_overlap) begin
                $display("%0t: boxes_overlap mismatch, expected %b actual %b",
                         $time, want.boxes_overlap, got.boxes_overlap);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [pmc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pmc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    pmc_pkg::in_item_t              s_item    = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    pmc_pkg::out_item_t             m_item;

    collision_scoreboard board = new();

    // Stimulus-side record of which pixels have been loaded since reset; a query
    // is only sent once every pixel of its overlap rectangle is loaded in both masks.
    bit [63:0] loaded_a [64];
    bit [63:0] loaded_b [64];

    int src_idle    = 0;    // percent of cycles the sender holds back
    int sink_idle   = 0;    // percent of cycles the receiver holds back
    int opaque_pct  = 20;   // chance that a filled pixel gets a non-key color
    int hold_cycles = 0;    // long receiver stall, counted down by the sink process
    int items_sent  = 0;

    pixel_mask_collision u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Timeout: far above the slowest legal run (every query walking 64 rows
    // behind a stalled receiver and an idle sender).
    initial begin
        #20_000_000;
        $display("Timeout at %0t, %0d results still owed", $time, board.pending.size());
        $display("*** FAILED ***");
        $finish;
    end

    // Monitor: everything is observed at the rising edge, before the block's
    // registers update.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) board.set_reg(cfg_index, cfg_wdata);
            if (s_valid && s_ready) board.note_item(s_item);
            if (m_valid && m_ready) board.check_result(m_item);
        end
    end

    // Result receiver: random back-pressure, or a long hold-off when asked.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles--;
            end else begin
                m_ready <= ($urandom_range(99) >= sink_idle);
            end
        end
    end

    function automatic pmc_pkg::in_item_t random_item();
        pmc_pkg::in_item_t it;
        it.func       = 1'($urandom_range(1));
        it.sprite_sel = 1'($urandom_range(1));
        it.pix_col    = 6'($urandom_range(63));
        it.pix_row    = 6'($urandom_range(63));
        it.pix_color  = 24'($urandom);
        it.a_pos_x    = 10'($urandom_range(1023));
        it.a_pos_y    = 10'($urandom_range(1023));
        it.b_pos_x    = 10'($urandom_range(1023));
        it.b_pos_y    = 10'($urandom_range(1023));
        return it;
    endfunction

    function automatic pmc_pkg::in_item_t query_at(int ax, int ay, int bx, int by);
        pmc_pkg::in_item_t it;
        it         = random_item();
        it.func    = pmc_pkg::FUNC_QUERY;
        it.a_pos_x = 10'(ax);
        it.a_pos_y = 10'(ay);
        it.b_pos_x = 10'(bx);
        it.b_pos_y = 10'(by);
        return it;
    endfunction

    function automatic int clamp_pos(int v);
        return (v < 0) ? 0 : ((v > 1023) ? 1023 : v);
    endfunction

    // Offer one item; returns at the falling edge after it was taken. Valid is
    // only lowered when the sender decides to idle, so back-to-back items keep
    // it high.
    task automatic push_item(pmc_pkg::in_item_t it);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic load_pixel(bit sel, int col, int row, logic [23:0] color);
        pmc_pkg::in_item_t it;
        it            = random_item();
        it.func       = pmc_pkg::FUNC_LOAD;
        it.sprite_sel = sel;
        it.pix_col    = 6'(col);
        it.pix_row    = 6'(row);
        it.pix_color  = color;
        if (sel) loaded_b[row][col] = 1'b1;
        else     loaded_a[row][col] = 1'b1;
        push_item(it);
    endtask

    task automatic load_random_pixel(bit sel, int col, int row);
        logic [23:0] color;
        color = ($urandom_range(99) < opaque_pct) ? 24'($urandom) : board.key;
        load_pixel(sel, col, row, color);
    endtask

    // Fill whatever the overlap still lacks, then send the query.
    task automatic send_query(pmc_pkg::in_item_t q);
        int a_col0, b_col0, a_row0, b_row0, cw, ch;
        if (board.overlap_rect(q, a_col0, b_col0, a_row0, b_row0, cw, ch)) begin
            for (int r = 0; r < ch; r++) begin
                for (int c = 0; c < cw; c++) begin
                    if (!loaded_a[a_row0 + r][a_col0 + c])
                        load_random_pixel(1'b0, a_col0 + c, a_row0 + r);
                    if (!loaded_b[b_row0 + r][b_col0 + c])
                        load_random_pixel(1'b1, b_col0 + c, b_row0 + r);
                end
            end
        end
        push_item(q);
    endtask

    // Mostly near-miss or overlapping placements, some near the screen edges,
    // a few anywhere on screen.
    task automatic send_random_query();
        int aw, ah, bw, bh, ax, ay, bx, by;
        aw = collision_scoreboard::fit_size(board.a_w, pmc_pkg::MAX_SPRITE_W_DEF);
        ah = collision_scoreboard::fit_size(board.a_h, pmc_pkg::MAX_SPRITE_H_DEF);
        bw = collision_scoreboard::fit_size(board.b_w, pmc_pkg::MAX_SPRITE_W_DEF);
        bh = collision_scoreboard::fit_size(board.b_h, pmc_pkg::MAX_SPRITE_H_DEF);
        if ($urandom_range(99) < 10) begin
            send_query(random_item() | query_at(0, 0, 0, 0));
        end else begin
            if ($urandom_range(9) == 0) begin
                ax = $urandom_range(1) ? int'($urandom_range(3))
                                       : 1023 - int'($urandom_range(3));
                ay = $urandom_range(1) ? int'($urandom_range(3))
                                       : 1023 - int'($urandom_range(3));
            end else begin
                ax = int'($urandom_range(1023));
                ay = int'($urandom_range(1023));
            end
            bx = clamp_pos(ax - (bw + 1) + int'($urandom_range(aw + bw + 2)));
            by = clamp_pos(ay - (bh + 1) + int'($urandom_range(ah + bh + 2)));
            send_query(query_at(ax, ay, bx, by));
        end
    endtask

    // Drain: no result owed, then enough cycles for trailing loads to retire.
    task automatic settle();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge aclk);
        repeat (80) @(negedge aclk);
    endtask

    task automatic write_regs(logic [23:0] key, int aw, int ah, int bw, int bh);
        cfg_we    <= 1'b1;
        cfg_index <= pmc_pkg::REG_KEY_COLOR;
        cfg_wdata <= key;
        @(negedge aclk);
        cfg_index <= pmc_pkg::REG_A_WIDTH;
        cfg_wdata <= 24'(aw);
        @(negedge aclk);
        cfg_index <= pmc_pkg::REG_A_HEIGHT;
        cfg_wdata <= 24'(ah);
        @(negedge aclk);
        cfg_index <= pmc_pkg::REG_B_WIDTH;
        cfg_wdata <= 24'(bw);
        @(negedge aclk);
        cfg_index <= pmc_pkg::REG_B_HEIGHT;
        cfg_wdata <= 24'(bh);
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // One register setting with ~290 items of random traffic.
    task automatic run_phase(int p);
        int phase_end;
        settle();
        case (p)
            // small square sprites
            0: begin write_regs(24'($urandom), 8, 8, 8, 8); opaque_pct = 20; end
            // zero sizes saturate to a single pixel
            1: begin write_regs(24'hffffff, 0, 0, 5, 3); opaque_pct = 60; end
            // full-width overlap: 127 saturates to 64 columns
            2: begin write_regs(24'h000000, 127, 2, 64, 3); opaque_pct = 8; end
            // tall, sparse sprites: long row walks
            3: begin write_regs(24'($urandom), 2, 64, 1, 100); opaque_pct = 3; end
            4: begin write_regs(24'h000001, 13, 7, 6, 11); opaque_pct = 15; end
            default: begin write_regs(24'($urandom), 64, 64, 20, 20); opaque_pct = 5; end
        endcase
        // sender/receiver idling: one way, then the other, then none
        if (p < 2) begin
            src_idle  = 34;
            sink_idle = 56;
        end else if (p < 4) begin
            src_idle  = 56;
            sink_idle = 34;
        end else begin
            src_idle  = 0;
            sink_idle = 0;
        end
        // long receiver stall while items keep coming: queue fills, s_ready drops
        if (p == 1 || p == 4) begin
            @(posedge aclk);
            hold_cycles = 300;
            @(negedge aclk);
        end
        phase_end = items_sent + 290;
        while (items_sent < phase_end) begin
            if ($urandom_range(99) < 20)
                load_random_pixel(1'($urandom_range(1)), int'($urandom_range(63)),
                                  int'($urandom_range(63)));
            else
                send_random_query();
        end
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        src_idle  = 34;
        sink_idle = 56;

        // Directed: 2x2 sprites, reset key color.
        write_regs(pmc_pkg::KEY_COLOR_RST, 2, 2, 2, 2);
        load_pixel(1'b0, 0, 0, 24'h000000);
        load_pixel(1'b0, 1, 0, pmc_pkg::KEY_COLOR_RST);
        load_pixel(1'b0, 0, 1, pmc_pkg::KEY_COLOR_RST);
        load_pixel(1'b0, 1, 1, 24'hffffff);
        load_pixel(1'b1, 0, 0, pmc_pkg::KEY_COLOR_RST);
        load_pixel(1'b1, 1, 0, pmc_pkg::KEY_COLOR_RST);
        load_pixel(1'b1, 0, 1, pmc_pkg::KEY_COLOR_RST);
        load_pixel(1'b1, 1, 1, 24'h123456);
        load_pixel(1'b0, 63, 63, 24'h00ff00);      // far corner, outside the sprite
        load_pixel(1'b1, 63, 63, pmc_pkg::KEY_COLOR_RST);
        send_query(query_at(0, 0, 1023, 1023));     // far apart
        send_query(query_at(0, 0, 2, 0));           // edges touch, no overlap
        send_query(query_at(5, 5, 5, 5));           // same place, hit
        send_query(query_at(5, 5, 6, 6));           // overlap, B pixel transparent
        send_query(query_at(6, 6, 5, 5));           // overlap, opaque pair
        send_query(query_at(1022, 1022, 1023, 1023)); // bottom-right screen edge
        send_query(query_at(1023, 1023, 1022, 1022));

        // Key change: pixels loaded earlier keep their opacity.
        settle();
        write_regs(24'h123456, 2, 2, 2, 2);
        send_query(query_at(5, 5, 5, 5));
        load_pixel(1'b1, 1, 1, 24'h123456);        // now transparent
        send_query(query_at(5, 5, 5, 5));

        for (int p = 0; p < 6; p++) run_phase(p);
        settle();

        $display("Run covered %0d loads and %0d queries (%0d box overlaps, %0d hits),",
                 board.n_loads, board.n_queries, board.n_overlaps, board.n_hits);
        $display("over eight register settings with both-side stalls; %0d mismatches",
                 board.errors);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
